### rtl/core/lla_pkg.sv
// lla_pkg: shared types, fixed-point constants and arithmetic helpers
// for the lab lightness adjuster; no dependencies
`timescale 1ns / 1ps

package lla_pkg;

    // fixed-point format: signed, FRAC_BITS fraction bits
    localparam int FRAC_BITS = 20;
    localparam int QW        = 32;
    typedef logic signed [QW-1:0] q_t;
    typedef logic [FRAC_BITS:0]   ch_t;

    localparam longint SC = longint'(1) << FRAC_BITS;

    localparam q_t ONE     = q_t'(SC);
    localparam q_t SIXTEEN = q_t'(16 * SC);
    localparam q_t HUNDRED = q_t'(100 * SC);
    localparam q_t K116    = q_t'(116);

    // request kinds
    localparam logic ADD_L = 1'b0;
    localparam logic SET_L = 1'b1;

    // rgb to xyz, row major
    localparam q_t TO_XYZ [9] = '{
        q_t'((412453 * SC + 500000) / 1000000),
        q_t'((357580 * SC + 500000) / 1000000),
        q_t'((180423 * SC + 500000) / 1000000),
        q_t'((212671 * SC + 500000) / 1000000),
        q_t'((715160 * SC + 500000) / 1000000),
        q_t'((72169 * SC + 500000) / 1000000),
        q_t'((19334 * SC + 500000) / 1000000),
        q_t'((119193 * SC + 500000) / 1000000),
        q_t'((950227 * SC + 500000) / 1000000)
    };

    // xyz to rgb, row major
    localparam q_t TO_RGB [9] = '{
        q_t'((3240479 * SC + 500000) / 1000000),
        q_t'(-((1537150 * SC + 500000) / 1000000)),
        q_t'(-((498535 * SC + 500000) / 1000000)),
        q_t'(-((969256 * SC + 500000) / 1000000)),
        q_t'((1875992 * SC + 500000) / 1000000),
        q_t'((41556 * SC + 500000) / 1000000),
        q_t'((55648 * SC + 500000) / 1000000),
        q_t'(-((204043 * SC + 500000) / 1000000)),
        q_t'((1057311 * SC + 500000) / 1000000)
    };

    localparam q_t WHITE_X   = q_t'((950456 * SC + 500000) / 1000000);
    localparam q_t WHITE_Z   = q_t'((1088754 * SC + 500000) / 1000000);
    localparam q_t LAB_EPS   = q_t'((8856 * SC + 500000) / 1000000);
    localparam q_t KAPPA     = q_t'((9033 * SC + 5) / 10);
    localparam q_t INV_KAPPA = q_t'((10 * SC + 4516) / 9033);
    localparam q_t LAB_KEPS  = q_t'((79996248 * SC + 5000000) / 10000000);

    // reciprocal of 116 for the estimate and correct divide
    localparam longint R116 = (longint'(1) << 32) / 116;

    // reciprocals of the white point for the normalization divide
    localparam longint RECIP_WX = (longint'(1) << (FRAC_BITS + 21)) / longint'(WHITE_X);
    localparam longint RECIP_WZ = (longint'(1) << (FRAC_BITS + 21)) / longint'(WHITE_Z);

    // lightness limits in q8.8
    localparam int LQ_MAX = 25600;

    // shared divider geometry
    localparam int DIV_NUM_W = 42;
    localparam int DIV_DEN_W = 22;
    localparam int DIV_Q_W   = 22;

    // input and result words
    typedef struct packed {
        logic               req_type;
        logic [23:0]        color_in;
        logic signed [15:0] lightness_arg;
    } in_word_t;

    typedef struct packed {
        logic [23:0] color_out;
        logic [14:0] lightness_in;
    } out_word_t;

    // per-pixel context carried beside the dividers
    typedef struct packed {
        logic               req_type;
        logic signed [15:0] arg;
        q_t [2:0]           v;
        q_t [2:0]           lin;
        q_t [2:0]           y;
    } ctx_t;

    localparam int CTX_W = $bits(ctx_t);

    // product scaled down, rounded toward minus infinity
    function automatic q_t mulq(q_t a, q_t b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return q_t'(p >>> FRAC_BITS);
    endfunction

    // floor(n / 3) by reciprocal, exact for any 32-bit n
    function automatic logic [31:0] div3(logic [31:0] n);
        logic [63:0] p;
        p = 64'(n) * 64'h00000000AAAAAAAB;
        return 32'(p >> 33);
    endfunction

    // estimate of floor(n / 116), low by at most one
    function automatic logic [21:0] div116_est(logic [27:0] n);
        logic [53:0] p;
        p = 54'(n) * 54'(R116);
        return 22'(p >> 32);
    endfunction

    // correction step of floor(n / 116)
    function automatic logic [21:0] div116_fix(logic [27:0] n, logic [21:0] qe);
        logic [28:0] prod;
        logic [28:0] r;
        prod = 29'(qe) * 29'd116;
        r    = 29'(n) - prod;
        return (r >= 29'd116) ? 22'(qe + 22'd1) : qe;
    endfunction

    // estimate of floor(n * 2^FRAC_BITS / w) from the reciprocal m, low by at most one
    function automatic logic [21:0] wpt_est(logic [21:0] n, logic [21:0] m);
        logic [43:0] p;
        p = 44'(n) * 44'(m);
        return 22'(p >> 21);
    endfunction

    // correction step of floor(n * 2^FRAC_BITS / w)
    function automatic logic [21:0] wpt_fix(logic [21:0] n, logic [21:0] w,
                                            logic [21:0] qe);
        logic [42:0] prod;
        logic [42:0] r;
        prod = 43'(qe) * 43'(w);
        r    = (43'(n) << FRAC_BITS) - prod;
        return (r >= 43'(w)) ? 22'(qe + 22'd1) : qe;
    endfunction

endpackage

### rtl/core/lla_div.sv
// lla_div: pipelined restoring divider, one quotient bit per stage,
// several lanes and a sideband word; no dependencies
`timescale 1ns / 1ps

module lla_div #(
    parameter int LANES  = 3,
    parameter int NUM_W  = 42,
    parameter int DEN_W  = 22,
    parameter int Q_W    = 22,
    parameter int SIDE_W = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]  num,
    input  logic [LANES-1:0][DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic [LANES-1:0][Q_W-1:0]    quo,
    output logic [SIDE_W-1:0]            side_out
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [Q_W-1:0]                      vld_reg;
    logic [Q_W-1:0][LANES-1:0][W-1:0]    rem_reg;
    logic [Q_W-1:0][LANES-1:0][DEN_W-1:0] den_reg;
    logic [Q_W-1:0][LANES-1:0][Q_W-1:0]  quo_reg;
    logic [Q_W-1:0][SIDE_W-1:0]          side_reg;

    genvar s, ln;
    generate
        for (s = 0; s < Q_W; s++)
        begin : g_stage
            logic                         vld_in;
            logic [LANES-1:0][W-1:0]      rem_in;
            logic [LANES-1:0][DEN_W-1:0]  den_in;
            logic [LANES-1:0][Q_W-1:0]    quo_in;
            logic [SIDE_W-1:0]            side_s;
            logic [LANES-1:0][W-1:0]      rem_next;
            logic [LANES-1:0][Q_W-1:0]    quo_next;

            // stage inputs
            if (s == 0)
            begin : g_first
                assign vld_in = in_valid;
                assign side_s = side_in;
                for (ln = 0; ln < LANES; ln++)
                begin : g_ln
                    assign rem_in[ln] = W'(num[ln]);
                    assign den_in[ln] = den[ln];
                    assign quo_in[ln] = '0;
                end
            end
            else
            begin : g_rest
                assign vld_in = vld_reg[s-1];
                assign side_s = side_reg[s-1];
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            // trial subtract for quotient bit Q_W-1-s
            for (ln = 0; ln < LANES; ln++)
            begin : g_trial
                logic [W-1:0] dsh;
                logic         take;
                assign dsh  = W'(den_in[ln]) << (Q_W - 1 - s);
                assign take = (rem_in[ln] >= dsh);
                assign rem_next[ln] = take ? (rem_in[ln] - dsh) : rem_in[ln];
                assign quo_next[ln] = Q_W'({quo_in[ln], take});
            end

            // valid with reset
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            // payload
            always_ff @(posedge clk)
            begin
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in;
                quo_reg[s]  <= quo_next;
                side_reg[s] <= side_s;
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

### rtl/core/lab_lightness_adjust.sv
// lab_lightness_adjust: top level, rgb to cie lab, lightness change, back to rgb
// depends on lla_pkg and lla_div
// each newton step holds a root divider, 22 stages with one quotient bit per stage
// throughput: one word per clock, busy is always low, results cannot be held off
// reset clears only the valid bits along the pipeline; no state links pixels
`timescale 1ns / 1ps

module lab_lightness_adjust #(
    parameter int CBRT_STEPS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lla_pkg::in_word_t request,
    output logic              done,
    output lla_pkg::out_word_t result
);

    import lla_pkg::*;

    // the pipeline never stalls
    assign busy = 1'b0;

    // ---------------- stage 1: channels to fixed point
    logic               s1_vld_reg;
    ch_t [2:0]          s1_ch_reg, s1_ch_next;
    logic               s1_req_reg;
    logic signed [15:0] s1_arg_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [7:0] c;
            logic [7:0] r;
            c = request.color_in[16-8*i +: 8];
            r = 8'({c[3:0], 4'd0}) + 8'(c[7:4]);
            s1_ch_next[i] = ch_t'(c) * ch_t'(4112) + ch_t'(c[7:4])
                          + ch_t'(r == 8'd255);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ch_reg  <= s1_ch_next;
        s1_req_reg <= request.req_type;
        s1_arg_reg <= request.lightness_arg;
    end

    // ---------------- stage 2: matrix products
    logic     s2_vld_reg;
    q_t [8:0] s2_prod_reg, s2_prod_next;
    logic     s2_req_reg;
    logic signed [15:0] s2_arg_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            s2_prod_next[k] = mulq(TO_XYZ[k], q_t'(s1_ch_reg[k % 3]));
        end
    end

    always_ff @(posedge clk)
    begin
        s2_prod_reg <= s2_prod_next;
        s2_req_reg  <= s1_req_reg;
        s2_arg_reg  <= s1_arg_reg;
    end

    // ---------------- stage 3: xyz sums
    logic     s3_vld_reg;
    q_t [2:0] s3_xyz_reg, s3_xyz_next;
    logic     s3_req_reg;
    logic signed [15:0] s3_arg_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_xyz_next[i] = s2_prod_reg[3*i] + s2_prod_reg[3*i+1] + s2_prod_reg[3*i+2];
        end
    end

    always_ff @(posedge clk)
    begin
        s3_xyz_reg <= s3_xyz_next;
        s3_req_reg <= s2_req_reg;
        s3_arg_reg <= s2_arg_reg;
    end

    // ---------------- white point normalization, reciprocal estimate
    logic             w1_vld_reg;
    ctx_t             w1_ctx_reg, w1_ctx_next;
    logic [1:0][21:0] w1_n_reg, w1_n_next;
    logic [1:0][21:0] w1_qe_reg, w1_qe_next;

    always_comb
    begin
        w1_n_next[0]         = s3_xyz_reg[0][21:0];
        w1_n_next[1]         = s3_xyz_reg[2][21:0];
        w1_qe_next[0]        = wpt_est(w1_n_next[0], 22'(RECIP_WX));
        w1_qe_next[1]        = wpt_est(w1_n_next[1], 22'(RECIP_WZ));
        w1_ctx_next          = '0;
        w1_ctx_next.req_type = s3_req_reg;
        w1_ctx_next.arg      = s3_arg_reg;
        w1_ctx_next.v[1]     = s3_xyz_reg[1];
    end

    always_ff @(posedge clk)
    begin
        w1_ctx_reg <= w1_ctx_next;
        w1_n_reg   <= w1_n_next;
        w1_qe_reg  <= w1_qe_next;
    end

    // ---------------- white point normalization, correction
    logic                    w2_vld_reg;
    ctx_t                    w2_ctx_reg;
    logic [1:0][DIV_Q_W-1:0] w2_quo_reg, w2_quo_next;

    always_comb
    begin
        w2_quo_next[0] = wpt_fix(w1_n_reg[0], 22'(WHITE_X), w1_qe_reg[0]);
        w2_quo_next[1] = wpt_fix(w1_n_reg[1], 22'(WHITE_Z), w1_qe_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        w2_ctx_reg <= w1_ctx_reg;
        w2_quo_reg <= w2_quo_next;
    end

    // ---------------- stage 4: root seed and linear branch product
    logic     s4_vld_reg;
    ctx_t     s4_ctx_reg, s4_ctx_next;
    q_t [2:0] s4_nlin_reg, s4_nlin_next;

    always_comb
    begin
        s4_ctx_next      = w2_ctx_reg;
        s4_ctx_next.v[0] = q_t'(32'(w2_quo_reg[0]));
        s4_ctx_next.v[2] = q_t'(32'(w2_quo_reg[1]));
        for (int i = 0; i < 3; i++)
        begin
            q_t vi;
            vi = q_t'(s4_ctx_next.v[i]);
            s4_nlin_next[i]  = mulq(KAPPA, vi) + SIXTEEN;
            s4_ctx_next.y[i] = q_t'(div3($unsigned(ONE) + ($unsigned(vi) << 1)));
        end
    end

    always_ff @(posedge clk)
    begin
        s4_ctx_reg  <= s4_ctx_next;
        s4_nlin_reg <= s4_nlin_next;
    end

    // ---------------- stage 5: divide by 116, estimate
    logic             s5_vld_reg;
    ctx_t             s5_ctx_reg;
    q_t [2:0]         s5_nlin_reg;
    logic [2:0][21:0] s5_qe_reg, s5_qe_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_qe_next[i] = div116_est(s4_nlin_reg[i][27:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        s5_ctx_reg  <= s4_ctx_reg;
        s5_nlin_reg <= s4_nlin_reg;
        s5_qe_reg   <= s5_qe_next;
    end

    // ---------------- stage 6: divide by 116, correction
    logic s6_vld_reg;
    ctx_t s6_ctx_reg, s6_ctx_next;

    always_comb
    begin
        s6_ctx_next = s5_ctx_reg;
        for (int i = 0; i < 3; i++)
        begin
            s6_ctx_next.lin[i] = q_t'(32'(div116_fix(s5_nlin_reg[i][27:0], s5_qe_reg[i])));
        end
    end

    always_ff @(posedge clk)
    begin
        s6_ctx_reg <= s6_ctx_next;
    end

    // ---------------- cube root newton steps
    ctx_t nt_ctx [CBRT_STEPS+1];
    logic nt_vld [CBRT_STEPS+1];

    assign nt_ctx[0] = s6_ctx_reg;
    assign nt_vld[0] = s6_vld_reg;

    genvar gk;
    generate
        for (gk = 0; gk < CBRT_STEPS; gk++)
        begin : g_newton
            logic                      na_vld_reg;
            ctx_t                      na_ctx_reg;
            logic [2:0][DIV_DEN_W-1:0] na_den_reg, na_den_next;
            logic [2:0][DIV_NUM_W-1:0] dv_num;
            logic                      dv_vld;
            logic [2:0][DIV_Q_W-1:0]   dv_quo;
            logic [CTX_W-1:0]          dv_side;
            ctx_t                      dv_ctx;
            logic                      nb_vld_reg;
            ctx_t                      nb_ctx_reg, nb_ctx_next;

            // square of the iterate, kept at least one lsb
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q_t sq;
                    sq = mulq(q_t'(nt_ctx[gk].y[i]), q_t'(nt_ctx[gk].y[i]));
                    na_den_next[i] = (sq[DIV_DEN_W-1:0] == '0) ? DIV_DEN_W'(1)
                                                               : sq[DIV_DEN_W-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    na_vld_reg <= 1'b0;
                    nb_vld_reg <= 1'b0;
                end
                else
                begin
                    na_vld_reg <= nt_vld[gk];
                    nb_vld_reg <= dv_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                na_ctx_reg <= nt_ctx[gk];
                na_den_reg <= na_den_next;
                nb_ctx_reg <= nb_ctx_next;
            end

            // v scaled up over the square
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_num[i] = DIV_NUM_W'($unsigned(na_ctx_reg.v[i])) << FRAC_BITS;
                end
            end

            lla_div #(
                .LANES  (3),
                .NUM_W  (DIV_NUM_W),
                .DEN_W  (DIV_DEN_W),
                .Q_W    (DIV_Q_W),
                .SIDE_W (CTX_W)
            ) u_div_root (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (na_vld_reg),
                .num       (dv_num),
                .den       (na_den_reg),
                .side_in   (na_ctx_reg),
                .out_valid (dv_vld),
                .quo       (dv_quo),
                .side_out  (dv_side)
            );

            assign dv_ctx = ctx_t'(dv_side);

            // next iterate (2y + v / y^2) / 3
            always_comb
            begin
                nb_ctx_next = dv_ctx;
                for (int i = 0; i < 3; i++)
                begin
                    logic [31:0] acc;
                    acc = ($unsigned(dv_ctx.y[i]) << 1) + 32'(dv_quo[i]);
                    nb_ctx_next.y[i] = q_t'(div3(acc));
                end
            end

            assign nt_ctx[gk+1] = nb_ctx_reg;
            assign nt_vld[gk+1] = nb_vld_reg;
        end
    endgenerate

    // ---------------- stage 7: pick root or linear branch
    logic     s7_vld_reg;
    q_t [2:0] s7_f_reg, s7_f_next;
    logic     s7_req_reg;
    logic signed [15:0] s7_arg_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s7_f_next[i] = (q_t'(nt_ctx[CBRT_STEPS].v[i]) > LAB_EPS)
                         ? q_t'(nt_ctx[CBRT_STEPS].y[i]) : q_t'(nt_ctx[CBRT_STEPS].lin[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        s7_f_reg   <= s7_f_next;
        s7_req_reg <= nt_ctx[CBRT_STEPS].req_type;
        s7_arg_reg <= nt_ctx[CBRT_STEPS].arg;
    end

    // ---------------- stage 8: l, color differences, scaled argument
    logic s8_vld_reg;
    q_t   s8_l_reg, s8_dx_reg, s8_dz_reg, s8_args_reg;
    q_t   s8_args_next;
    logic s8_req_reg;

    always_comb
    begin
        logic signed [15:0] ac;
        if (s7_arg_reg > 16'sd25600)
        begin
            ac = 16'sd25600;
        end
        else if (s7_arg_reg < -16'sd25600)
        begin
            ac = -16'sd25600;
        end
        else
        begin
            ac = s7_arg_reg;
        end
        s8_args_next = q_t'(ac) <<< (FRAC_BITS - 8);
    end

    always_ff @(posedge clk)
    begin
        s8_l_reg    <= s7_f_reg[1] * K116 - SIXTEEN;
        s8_dx_reg   <= s7_f_reg[0] - s7_f_reg[1];
        s8_dz_reg   <= s7_f_reg[1] - s7_f_reg[2];
        s8_args_reg <= s8_args_next;
        s8_req_reg  <= s7_req_reg;
    end

    // ---------------- stage 9: reported lightness and new l
    logic        s9_vld_reg;
    logic [14:0] s9_lq8_reg, s9_lq8_next;
    q_t          s9_lt_reg, s9_lt_next;
    q_t          s9_dx_reg, s9_dz_reg;

    always_comb
    begin
        q_t lsh;
        q_t sum;
        lsh = s8_l_reg >>> (FRAC_BITS - 8);
        if (lsh < 0)
        begin
            s9_lq8_next = '0;
        end
        else if (lsh > q_t'(LQ_MAX))
        begin
            s9_lq8_next = 15'(LQ_MAX);
        end
        else
        begin
            s9_lq8_next = lsh[14:0];
        end
        sum = (s8_req_reg == SET_L) ? s8_args_reg : s8_l_reg + s8_args_reg;
        if (sum < 0)
        begin
            s9_lt_next = '0;
        end
        else if (sum > HUNDRED)
        begin
            s9_lt_next = HUNDRED;
        end
        else
        begin
            s9_lt_next = sum;
        end
    end

    always_ff @(posedge clk)
    begin
        s9_lq8_reg <= s9_lq8_next;
        s9_lt_reg  <= s9_lt_next;
        s9_dx_reg  <= s8_dx_reg;
        s9_dz_reg  <= s8_dz_reg;
    end

    // ---------------- stage 10: fy estimate
    logic        s10_vld_reg;
    logic [14:0] s10_lq8_reg;
    q_t          s10_lt_reg, s10_dx_reg, s10_dz_reg;
    logic [27:0] s10_n_reg;
    logic [21:0] s10_qe_reg;

    always_ff @(posedge clk)
    begin
        s10_lq8_reg <= s9_lq8_reg;
        s10_lt_reg  <= s9_lt_reg;
        s10_dx_reg  <= s9_dx_reg;
        s10_dz_reg  <= s9_dz_reg;
        s10_n_reg   <= 28'(s9_lt_reg + SIXTEEN);
        s10_qe_reg  <= div116_est(28'(s9_lt_reg + SIXTEEN));
    end

    // ---------------- stage 11: fy correction
    logic        s11_vld_reg;
    logic [14:0] s11_lq8_reg;
    q_t          s11_lt_reg, s11_dx_reg, s11_dz_reg, s11_fy_reg;

    always_ff @(posedge clk)
    begin
        s11_lq8_reg <= s10_lq8_reg;
        s11_lt_reg  <= s10_lt_reg;
        s11_dx_reg  <= s10_dx_reg;
        s11_dz_reg  <= s10_dz_reg;
        s11_fy_reg  <= q_t'(32'(div116_fix(s10_n_reg, s10_qe_reg)));
    end

    // ---------------- stage 12: fx, fz and y square
    logic        s12_vld_reg;
    logic [14:0] s12_lq8_reg;
    q_t          s12_fa_reg, s12_fc_reg, s12_fy_reg, s12_lt_reg;
    q_t          s12_ysq_reg, s12_ylin_reg;

    always_ff @(posedge clk)
    begin
        s12_lq8_reg  <= s11_lq8_reg;
        s12_fa_reg   <= s11_dx_reg + s11_fy_reg;
        s12_fc_reg   <= s11_fy_reg - s11_dz_reg;
        s12_fy_reg   <= s11_fy_reg;
        s12_lt_reg   <= s11_lt_reg;
        s12_ysq_reg  <= mulq(s11_fy_reg, s11_fy_reg);
        s12_ylin_reg <= mulq(s11_lt_reg, INV_KAPPA);
    end

    // ---------------- stage 13: squares and linear inverse
    logic        s13_vld_reg;
    logic [14:0] s13_lq8_reg;
    q_t          s13_fa_reg, s13_fc_reg, s13_fa2_reg, s13_fc2_reg;
    q_t          s13_alin_reg, s13_clin_reg, s13_ycube_reg, s13_ylin_reg, s13_lt_reg;

    always_ff @(posedge clk)
    begin
        s13_lq8_reg   <= s12_lq8_reg;
        s13_fa_reg    <= s12_fa_reg;
        s13_fc_reg    <= s12_fc_reg;
        s13_fa2_reg   <= mulq(s12_fa_reg, s12_fa_reg);
        s13_fc2_reg   <= mulq(s12_fc_reg, s12_fc_reg);
        s13_alin_reg  <= mulq(s12_fa_reg * K116 - SIXTEEN, INV_KAPPA);
        s13_clin_reg  <= mulq(s12_fc_reg * K116 - SIXTEEN, INV_KAPPA);
        s13_ycube_reg <= mulq(s12_ysq_reg, s12_fy_reg);
        s13_ylin_reg  <= s12_ylin_reg;
        s13_lt_reg    <= s12_lt_reg;
    end

    // ---------------- stage 14: inverse lab function
    logic        s14_vld_reg;
    logic [14:0] s14_lq8_reg;
    q_t          s14_xi_reg, s14_yv_reg, s14_zi_reg;

    always_ff @(posedge clk)
    begin
        s14_lq8_reg <= s13_lq8_reg;
        s14_xi_reg  <= (s13_fa_reg > LAB_EPS) ? mulq(s13_fa2_reg, s13_fa_reg) : s13_alin_reg;
        s14_zi_reg  <= (s13_fc_reg > LAB_EPS) ? mulq(s13_fc2_reg, s13_fc_reg) : s13_clin_reg;
        s14_yv_reg  <= (s13_lt_reg > LAB_KEPS) ? s13_ycube_reg : s13_ylin_reg;
    end

    // ---------------- stage 15: white point
    logic        s15_vld_reg;
    logic [14:0] s15_lq8_reg;
    q_t [2:0]    s15_xyz_reg;

    always_ff @(posedge clk)
    begin
        s15_lq8_reg    <= s14_lq8_reg;
        s15_xyz_reg[0] <= mulq(s14_xi_reg, WHITE_X);
        s15_xyz_reg[1] <= s14_yv_reg;
        s15_xyz_reg[2] <= mulq(s14_zi_reg, WHITE_Z);
    end

    // ---------------- stage 16: inverse matrix products
    logic        s16_vld_reg;
    logic [14:0] s16_lq8_reg;
    q_t [8:0]    s16_prod_reg, s16_prod_next;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            s16_prod_next[k] = mulq(TO_RGB[k], q_t'(s15_xyz_reg[k % 3]));
        end
    end

    always_ff @(posedge clk)
    begin
        s16_lq8_reg  <= s15_lq8_reg;
        s16_prod_reg <= s16_prod_next;
    end

    // ---------------- stage 17: channel sums clamped to 0..1
    logic        s17_vld_reg;
    logic [14:0] s17_lq8_reg;
    ch_t [2:0]   s17_lin_reg, s17_lin_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_t sum;
            sum = s16_prod_reg[3*i] + s16_prod_reg[3*i+1] + s16_prod_reg[3*i+2];
            if (sum < 0)
            begin
                s17_lin_next[i] = '0;
            end
            else if (sum > ONE)
            begin
                s17_lin_next[i] = ch_t'(ONE);
            end
            else
            begin
                s17_lin_next[i] = sum[FRAC_BITS:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s17_lq8_reg <= s16_lq8_reg;
        s17_lin_reg <= s17_lin_next;
    end

    // ---------------- stage 18: scale to 8 bits, result word
    out_word_t res_reg, res_next;
    logic      done_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [FRAC_BITS+8:0] m;
            m = (FRAC_BITS + 9)'(s17_lin_reg[i]) * (FRAC_BITS + 9)'(255);
            res_next.color_out[16-8*i +: 8] = m[FRAC_BITS +: 8];
        end
        res_next.lightness_in = s17_lq8_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // valid bits along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            w1_vld_reg  <= 1'b0;
            w2_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            s15_vld_reg <= 1'b0;
            s16_vld_reg <= 1'b0;
            s17_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= start & ~busy;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            w1_vld_reg  <= s3_vld_reg;
            w2_vld_reg  <= w1_vld_reg;
            s4_vld_reg  <= w2_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= nt_vld[CBRT_STEPS];
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= s12_vld_reg;
            s14_vld_reg <= s13_vld_reg;
            s15_vld_reg <= s14_vld_reg;
            s16_vld_reg <= s15_vld_reg;
            s17_vld_reg <= s16_vld_reg;
            done_reg    <= s17_vld_reg;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
